/* rtl/core/mmwg_pkg.sv */
// Shared constants, register indexes, wave mode codes and the quarter-wave sine table
// of the waveform generator. Depends on nothing.
package mmwg_pkg;

   localparam int TIME_BITS   = 32;
   localparam int PERIOD_BITS = 24;
   localparam int AMP_BITS    = 14;
   localparam int COUNT_BITS  = 8;
   localparam int LEVEL_BITS  = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   localparam int PHASE_BITS      = 12;
   localparam int SINE_DEPTH      = 256;
   localparam int SINE_ADDR_BITS  = $clog2(SINE_DEPTH);
   localparam int QUAD_BITS       = PHASE_BITS - 2;
   localparam int SINE_IDX_BITS   = SINE_ADDR_BITS + 1;
   localparam int SINE_FRAC_BITS  = 15;

   // magnitude fed to the scaler: sine up to 2^15, ramps up to 2^PHASE_BITS
   localparam int MAG_BITS  = SINE_FRAC_BITS + 1;
   localparam int PROD_BITS = AMP_BITS + MAG_BITS;
   // long division of {time, PHASE_BITS zeros} by the period
   localparam int DVD_BITS  = TIME_BITS + PHASE_BITS;
   localparam int CNT_BITS  = $clog2(DVD_BITS);
   localparam int BOUND_BITS = PERIOD_BITS + 3;
   // internal level before saturation
   localparam int LVL_BITS  = LEVEL_BITS + 2;

   localparam logic [3:0] MODE_SINE     = 4'd0;
   localparam logic [3:0] MODE_STEP     = 4'd1;
   localparam logic [3:0] MODE_MANUAL   = 4'd2;
   localparam logic [3:0] MODE_HOLD     = 4'd3;
   localparam logic [3:0] MODE_TRIANGLE = 4'd4;
   localparam logic [3:0] MODE_SAWTOOTH = 4'd5;
   localparam logic [3:0] MODE_SQUARE   = 4'd6;
   localparam logic [3:0] MODE_POS_STEP = 4'd7;
   localparam logic [3:0] MODE_NEG_STEP = 4'd8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WAVE_MODE  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONTINUOUS = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AMPLITUDE  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CYCLES     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIAS       = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_DUR   = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_LEVEL = 3'd7;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [SINE_DEPTH:0][MAG_BITS-1:0] sine_tab_type;

   // Q15 quarter-wave sine, Taylor series in Q30, evaluated at elaboration
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      logic [63:0] theta;
      logic [63:0] th2;
      logic [63:0] term;
      logic [63:0] e;
      logic signed [63:0] sum;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         theta = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
         th2   = (theta * theta) >> 30;
         term  = theta;
         sum   = $signed(theta);
         term = ((term * th2) >> 30) / 64'd6;   sum = sum - $signed(term);
         term = ((term * th2) >> 30) / 64'd20;  sum = sum + $signed(term);
         term = ((term * th2) >> 30) / 64'd42;  sum = sum - $signed(term);
         term = ((term * th2) >> 30) / 64'd72;  sum = sum + $signed(term);
         term = ((term * th2) >> 30) / 64'd110; sum = sum - $signed(term);
         term = ((term * th2) >> 30) / 64'd156; sum = sum + $signed(term);
         term = ((term * th2) >> 30) / 64'd210; sum = sum - $signed(term);
         term = ((term * th2) >> 30) / 64'd272; sum = sum + $signed(term);
         if (sum < 0) begin
            sum = '0;
         end
         e = ($unsigned(sum) + 64'd16384) >> 15;
         if (e > 64'd32768) begin
            e = 64'd32768;
         end
         tab[k] = e[MAG_BITS-1:0];
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

/* rtl/core/multi_mode_waveform_generator_top.sv */
// Waveform generator top level: configuration registers, bit-serial divider and
// multipliers, step sequencer and result register. Depends on mmwg_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_time_us
//   rsp      out        rsp_valid / rsp_ready  rsp_time_echo, rsp_level_mv
//   csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// Sine, triangle and sawtooth pass through the bit-serial division of the timestamp by
// the period, a shaping state, shift-add amplitude scaling, rounding, hand-off and idle.
// Square and a finished run skip the scaling and rounding, a zero period goes straight
// to the hand-off. Step modes walk the segment bounds, one bound compare a cycle; manual
// and hold go straight to the hand-off. Synchronous reset loads register defaults. One
// transaction is in work at a time; a held result stalls only the hand-off.
module multi_mode_waveform_generator_top
   import mmwg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [TIME_BITS-1:0]          req_time_us,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [TIME_BITS-1:0]          rsp_time_echo,
   output logic signed [LEVEL_BITS-1:0]  rsp_level_mv,
   input  logic                          csr_we,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_SHAPE, S_MUL, S_ROUND, S_STEP, S_DONE
   } state_type;

   localparam logic [PHASE_BITS-1:0] PH_QUARTER = PHASE_BITS'(1 << (PHASE_BITS - 2));
   localparam logic [PHASE_BITS-1:0] PH_HALF    = PHASE_BITS'(1 << (PHASE_BITS - 1));
   localparam logic [PHASE_BITS-1:0] PH_3QUART  = PHASE_BITS'(3 << (PHASE_BITS - 2));
   localparam logic [PHASE_BITS+3:0] RAMP_2M    = (PHASE_BITS+4)'(1 << (PHASE_BITS + 1));
   localparam logic [PHASE_BITS+3:0] RAMP_4M    = (PHASE_BITS+4)'(1 << (PHASE_BITS + 2));
   localparam logic signed [LVL_BITS-1:0] SAT_HI = LVL_BITS'((1 << (LEVEL_BITS - 1)) - 1);
   localparam logic signed [LVL_BITS-1:0] SAT_LO = -LVL_BITS'(1 << (LEVEL_BITS - 1));

   // control and configuration
   state_type                      state_ff, state_in;
   logic [3:0]                     wave_mode_ff, wave_mode_in;
   logic [PERIOD_BITS-1:0]         period_ff, period_in;
   logic                           continuous_ff, continuous_in;
   logic [AMP_BITS-1:0]            amplitude_ff, amplitude_in;
   logic [COUNT_BITS-1:0]          cycles_ff, cycles_in;
   logic signed [AMP_BITS-1:0]     bias_ff, bias_in;
   logic [PERIOD_BITS-1:0]         step_dur_ff, step_dur_in;
   logic [AMP_BITS-1:0]            step_level_ff, step_level_in;
   logic signed [LEVEL_BITS-1:0]   last_level_ff, last_level_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0]            cnt_ff, cnt_in;

   // datapath
   logic [TIME_BITS-1:0]           time_ff, time_in;
   logic [DVD_BITS-1:0]            dvd_ff, dvd_in;
   logic [PERIOD_BITS-1:0]         rem_ff, rem_in;
   logic [TIME_BITS-1:0]           fin_acc_ff, fin_acc_in;
   logic [TIME_BITS-1:0]           fin_mcand_ff, fin_mcand_in;
   logic [COUNT_BITS-1:0]          fin_mplier_ff, fin_mplier_in;
   logic [PROD_BITS-1:0]           mul_acc_ff, mul_acc_in;
   logic [PROD_BITS-1:0]           mul_mcand_ff, mul_mcand_in;
   logic [MAG_BITS-1:0]            mul_mplier_ff, mul_mplier_in;
   logic                           neg_ff, neg_in;
   logic                           sine_ff, sine_in;
   logic [BOUND_BITS-1:0]          bound_ff, bound_in;
   logic [1:0]                     seg_ff, seg_in;
   logic signed [LVL_BITS-1:0]     lvl_ff, lvl_in;
   logic [TIME_BITS-1:0]           rsp_time_ff, rsp_time_in;
   logic signed [LEVEL_BITS-1:0]   rsp_level_ff, rsp_level_in;

   // combinational helpers
   logic [PERIOD_BITS:0]           div_shift;
   logic [PERIOD_BITS:0]           div_diff;
   logic                           div_qbit;
   logic [PHASE_BITS-1:0]          ph;
   logic [1:0]                     quad;
   logic [SINE_ADDR_BITS-1:0]      sine_idx;
   logic [SINE_IDX_BITS-1:0]       sine_addr;
   logic [PHASE_BITS+3:0]          ph4;
   logic [PROD_BITS:0]             round_sum;
   logic signed [LVL_BITS-1:0]     round_mag;
   logic signed [LVL_BITS-1:0]     bias_ext;
   logic signed [LVL_BITS-1:0]     amp_ext;
   logic signed [LVL_BITS-1:0]     vstep_ext;
   logic signed [LEVEL_BITS-1:0]   lvl_sat;
   logic                           push;

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_time_echo = rsp_time_ff;
   assign rsp_level_mv  = rsp_level_ff;

   assign bias_ext  = LVL_BITS'(bias_ff);
   assign amp_ext   = $signed({{(LVL_BITS-AMP_BITS){1'b0}}, amplitude_ff});
   assign vstep_ext = $signed({{(LVL_BITS-AMP_BITS){1'b0}}, step_level_ff});

   // one restoring-division step
   assign div_shift = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign div_diff  = div_shift - {1'b0, period_ff};
   assign div_qbit  = (div_shift >= {1'b0, period_ff});

   assign ph        = dvd_ff[PHASE_BITS-1:0];
   assign quad      = ph[PHASE_BITS-1:PHASE_BITS-2];
   assign sine_idx  = ph[QUAD_BITS-1:QUAD_BITS-SINE_ADDR_BITS];
   assign sine_addr = quad[0] ? SINE_IDX_BITS'(SINE_DEPTH) - {1'b0, sine_idx}
                              : {1'b0, sine_idx};
   assign ph4       = {2'b00, ph, 2'b00};

   assign round_sum = sine_ff
      ? {1'b0, mul_acc_ff} + (PROD_BITS+1)'(1 << (SINE_FRAC_BITS - 1))
      : {1'b0, mul_acc_ff} + (PROD_BITS+1)'(1 << (PHASE_BITS - 1));
   assign round_mag = sine_ff ? $signed(LVL_BITS'(round_sum >> SINE_FRAC_BITS))
                              : $signed(LVL_BITS'(round_sum >> PHASE_BITS));

   always_comb begin
      if (lvl_ff > SAT_HI) begin
         lvl_sat = SAT_HI[LEVEL_BITS-1:0];
      end else if (lvl_ff < SAT_LO) begin
         lvl_sat = SAT_LO[LEVEL_BITS-1:0];
      end else begin
         lvl_sat = lvl_ff[LEVEL_BITS-1:0];
      end
   end

   assign push = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in       = state_ff;
      wave_mode_in   = wave_mode_ff;
      period_in      = period_ff;
      continuous_in  = continuous_ff;
      amplitude_in   = amplitude_ff;
      cycles_in      = cycles_ff;
      bias_in        = bias_ff;
      step_dur_in    = step_dur_ff;
      step_level_in  = step_level_ff;
      last_level_in  = last_level_ff;
      rsp_valid_in   = rsp_valid_ff;
      cnt_in         = cnt_ff;
      time_in        = time_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      fin_acc_in     = fin_acc_ff;
      fin_mcand_in   = fin_mcand_ff;
      fin_mplier_in  = fin_mplier_ff;
      mul_acc_in     = mul_acc_ff;
      mul_mcand_in   = mul_mcand_ff;
      mul_mplier_in  = mul_mplier_ff;
      neg_in         = neg_ff;
      sine_in        = sine_ff;
      bound_in       = bound_ff;
      seg_in         = seg_ff;
      lvl_in         = lvl_ff;
      rsp_time_in    = rsp_time_ff;
      rsp_level_in   = rsp_level_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_WAVE_MODE:  wave_mode_in  = csr_wdata[3:0];
            CSR_PERIOD:     period_in     = csr_wdata[PERIOD_BITS-1:0];
            CSR_CONTINUOUS: continuous_in = csr_wdata[0];
            CSR_AMPLITUDE:  amplitude_in  = csr_wdata[AMP_BITS-1:0];
            CSR_CYCLES:     cycles_in     = csr_wdata[COUNT_BITS-1:0];
            CSR_BIAS:       bias_in       = $signed(csr_wdata[AMP_BITS-1:0]);
            CSR_STEP_DUR:   step_dur_in   = csr_wdata[PERIOD_BITS-1:0];
            CSR_STEP_LEVEL: step_level_in = csr_wdata[AMP_BITS-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               time_in       = req_time_us;
               dvd_in        = {req_time_us, {PHASE_BITS{1'b0}}};
               rem_in        = '0;
               cnt_in        = '0;
               fin_acc_in    = '0;
               fin_mcand_in  = TIME_BITS'(period_ff);
               fin_mplier_in = cycles_ff;
               bound_in      = BOUND_BITS'(step_dur_ff);
               seg_in        = '0;
               case (wave_mode_ff) inside
                  MODE_SINE, MODE_TRIANGLE, MODE_SAWTOOTH, MODE_SQUARE: begin
                     if (period_ff == '0) begin
                        lvl_in   = bias_ext;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  MODE_STEP, MODE_POS_STEP, MODE_NEG_STEP: state_in = S_STEP;
                  MODE_MANUAL: begin
                     lvl_in   = vstep_ext;
                     state_in = S_DONE;
                  end
                  default: begin
                     // hold and unused codes repeat the previous level
                     lvl_in   = LVL_BITS'(last_level_ff);
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_DIV: begin
            dvd_in        = {dvd_ff[DVD_BITS-2:0], div_qbit};
            rem_in        = div_qbit ? div_diff[PERIOD_BITS-1:0]
                                     : div_shift[PERIOD_BITS-1:0];
            // cycle_count * period, one multiplier bit a cycle alongside
            fin_acc_in    = fin_acc_ff + (fin_mplier_ff[0] ? fin_mcand_ff : '0);
            fin_mcand_in  = {fin_mcand_ff[TIME_BITS-2:0], 1'b0};
            fin_mplier_in = {1'b0, fin_mplier_ff[COUNT_BITS-1:1]};
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DVD_BITS - 1)) begin
               state_in = S_SHAPE;
            end
         end

         S_SHAPE: begin
            cnt_in        = '0;
            mul_acc_in    = '0;
            mul_mcand_in  = PROD_BITS'(amplitude_ff);
            sine_in       = 1'b0;
            neg_in        = 1'b0;
            mul_mplier_in = MAG_BITS'(ph);
            state_in      = S_MUL;
            if (!continuous_ff && (fin_acc_ff < time_ff)) begin
               lvl_in   = bias_ext;
               state_in = S_DONE;
            end else begin
               case (wave_mode_ff) inside
                  MODE_SINE: begin
                     sine_in       = 1'b1;
                     neg_in        = quad[1];
                     mul_mplier_in = SINE_TAB[sine_addr];
                  end
                  MODE_TRIANGLE: begin
                     if (ph < PH_QUARTER) begin
                        mul_mplier_in = MAG_BITS'(ph4);
                     end else if (ph < PH_3QUART) begin
                        if (ph <= PH_HALF) begin
                           mul_mplier_in = MAG_BITS'(RAMP_2M - ph4);
                        end else begin
                           neg_in        = 1'b1;
                           mul_mplier_in = MAG_BITS'(ph4 - RAMP_2M);
                        end
                     end else begin
                        neg_in        = 1'b1;
                        mul_mplier_in = MAG_BITS'(RAMP_4M - ph4);
                     end
                  end
                  MODE_SAWTOOTH: mul_mplier_in = MAG_BITS'(ph);
                  default: begin
                     // square: no scaling needed
                     lvl_in   = (ph <= PH_HALF) ? bias_ext + amp_ext : bias_ext - amp_ext;
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_MUL: begin
            mul_acc_in    = mul_acc_ff + (mul_mplier_ff[0] ? mul_mcand_ff : '0);
            mul_mcand_in  = {mul_mcand_ff[PROD_BITS-2:0], 1'b0};
            mul_mplier_in = {1'b0, mul_mplier_ff[MAG_BITS-1:1]};
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(MAG_BITS - 1)) begin
               state_in = S_ROUND;
            end
         end

         S_ROUND: begin
            lvl_in   = neg_ff ? bias_ext - round_mag : bias_ext + round_mag;
            state_in = S_DONE;
         end

         S_STEP: begin
            // walk the segment bounds T, 2T, 3T, 4T, one compare a cycle
            if (TIME_BITS'(bound_ff) >= time_ff || seg_ff == 2'd3) begin
               lvl_in   = '0;
               state_in = S_DONE;
               if (TIME_BITS'(bound_ff) >= time_ff) begin
                  if (seg_ff == 2'd1 && wave_mode_ff != MODE_NEG_STEP) begin
                     lvl_in = vstep_ext;
                  end else if (seg_ff == 2'd3 && wave_mode_ff != MODE_POS_STEP) begin
                     lvl_in = -vstep_ext;
                  end
               end
            end else begin
               bound_in = bound_ff + BOUND_BITS'(step_dur_ff);
               seg_in   = seg_ff + 2'd1;
            end
         end

         S_DONE: begin
            if (push) begin
               rsp_valid_in  = 1'b1;
               rsp_time_in   = time_ff;
               rsp_level_in  = lvl_sat;
               last_level_in = lvl_sat;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wave_mode_ff  <= MODE_SINE;
         period_ff     <= PERIOD_BITS'(1000000);
         continuous_ff <= 1'b0;
         amplitude_ff  <= AMP_BITS'(1000);
         cycles_ff     <= COUNT_BITS'(5);
         bias_ff       <= '0;
         step_dur_ff   <= PERIOD_BITS'(250000);
         step_level_ff <= AMP_BITS'(2000);
         last_level_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         wave_mode_ff  <= wave_mode_in;
         period_ff     <= period_in;
         continuous_ff <= continuous_in;
         amplitude_ff  <= amplitude_in;
         cycles_ff     <= cycles_in;
         bias_ff       <= bias_in;
         step_dur_ff   <= step_dur_in;
         step_level_ff <= step_level_in;
         last_level_ff <= last_level_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff       <= time_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      fin_acc_ff    <= fin_acc_in;
      fin_mcand_ff  <= fin_mcand_in;
      fin_mplier_ff <= fin_mplier_in;
      mul_acc_ff    <= mul_acc_in;
      mul_mcand_ff  <= mul_mcand_in;
      mul_mplier_ff <= mul_mplier_in;
      neg_ff        <= neg_in;
      sine_ff       <= sine_in;
      bound_ff      <= bound_in;
      seg_ff        <= seg_in;
      lvl_ff        <= lvl_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_level_ff  <= rsp_level_in;
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("accepted transaction did not start work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the hand-off state");

   a_rem_below_period: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < period_ff)
      else $error("division remainder reached the period");

   a_last_level_tracks: assert property (@(posedge clock) disable iff (reset)
      push |=> last_level_ff == rsp_level_mv && rsp_valid)
      else $error("held level differs from the delivered level");
`endif

endmodule
